FILE: src/pps_pkg.sv
package pps_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_EXIT = 2'd2;

    typedef struct packed {
        logic [15:0] cpu_time;
        logic [7:0]  prio;
        logic [7:0]  id;
    } entry_t;

    // sort key: priority first, then cpu time
    typedef logic [23:0] key_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_SWAP
    } cell_op_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        cell_op_t op;
        key_t     key;
        entry_t   new_entry;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        entry_t entry;
        logic   lt;
    } cell_link_t;

    function automatic key_t entry_key(entry_t e);
        return {e.prio, e.cpu_time};
    endfunction

endpackage

FILE: src/preemptive_priority_sjf_scheduler.sv
// Preemptive priority / shortest-job-first scheduler for one CPU. Each item is
// a load (queue a task), a tick (start the head task when idle, or preempt the
// running task when the head's key {priority, cpu_time} is strictly smaller)
// or an exit (the head task takes over, or the CPU goes idle). Every item
// gives one result: the task now running, an idle flag, and a flag for a load
// dropped because the queue was full. The ready queue is a row of QUEUE_DEPTH
// cells sorted head first; a load or a preemption is broadcast to all cells,
// each compares its own key and shifts or takes the new task, so no item needs
// a pass along the row. The result sits in an output register and the block
// takes one item per cycle as long as results are taken. Among equal keys the
// most recently queued task is served first. No clearing pass after reset.
module preemptive_priority_sjf_scheduler
    import pps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  task_id,
    input  logic [7:0]  priority_req,
    input  logic [15:0] cpu_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  run_task,
    output logic        run_idle,
    output logic        load_dropped
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // queue fill level
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // running task
    entry_t run_entry_reg;
    entry_t run_entry_next;
    logic   run_valid_reg;
    logic   run_valid_next;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] run_task_reg;
    logic [7:0] run_task_next;
    logic       run_idle_reg;
    logic       run_idle_next;
    logic       dropped_reg;
    logic       dropped_next;

    logic       accept;
    logic       queue_empty;
    logic       queue_full;
    entry_t     in_entry;
    cell_ctrl_t ctrl;

    cell_link_t       links [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occupied;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign in_entry.id       = task_id;
    assign in_entry.prio     = priority_req;
    assign in_entry.cpu_time = cpu_time;

    // Row of cells, head at cell 0.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            cell_link_t below_link;
            cell_link_t above_link;

            assign occupied[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                // nothing ahead of the head: an insert stops here at the latest
                assign below_link = '{entry: '0, lt: 1'b1};
            end
            else
            begin : g_mid
                assign below_link = links[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign above_link = '{entry: '0, lt: 1'b0};
            end
            else
            begin : g_body
                assign above_link = links[gi+1];
            end

            pps_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occupied (occupied[gi]),
                .below    (below_link),
                .above    (above_link),
                .link     (links[gi])
            );
        end
    endgenerate

    // Decode one item. For a tick the cells compare against the running key,
    // so the head cell's lt flag is the preemption test itself.
    always_comb
    begin
        ctrl.op        = CELL_HOLD;
        ctrl.key       = entry_key(run_entry_reg);
        ctrl.new_entry = run_entry_reg;
        count_next     = count_reg;
        run_entry_next = run_entry_reg;
        run_valid_next = run_valid_reg;
        dropped_next   = 1'b0;

        if (accept)
        begin
            unique case (action)
                ACT_LOAD:
                begin
                    ctrl.key       = entry_key(in_entry);
                    ctrl.new_entry = in_entry;
                    if (queue_full)
                        dropped_next = 1'b1;
                    else
                    begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    if (!queue_empty)
                    begin
                        if (!run_valid_reg)
                        begin
                            ctrl.op        = CELL_POP;
                            count_next     = count_reg - 1'b1;
                            run_entry_next = links[0].entry;
                            run_valid_next = 1'b1;
                        end
                        else if (links[0].lt)
                        begin
                            // preempt: head runs, running task goes back in order
                            ctrl.op        = CELL_SWAP;
                            run_entry_next = links[0].entry;
                        end
                    end
                end
                ACT_EXIT:
                begin
                    if (!queue_empty)
                    begin
                        ctrl.op        = CELL_POP;
                        count_next     = count_reg - 1'b1;
                        run_entry_next = links[0].entry;
                        run_valid_next = 1'b1;
                    end
                    else
                        run_valid_next = 1'b0;
                end
                default:
                begin
                    // unused code: state is only reported
                end
            endcase
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        run_task_next  = run_task_reg;
        run_idle_next  = run_idle_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            run_task_next  = run_valid_next ? run_entry_next.id : 8'd0;
            run_idle_next  = !run_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_entry_reg <= run_entry_next;
        run_task_reg  <= run_task_next;
        run_idle_reg  <= run_idle_next;
        if (accept)
            dropped_reg <= dropped_next;
    end

    assign out_valid    = out_valid_reg;
    assign run_task     = run_task_reg;
    assign run_idle     = run_idle_reg;
    assign load_dropped = dropped_reg;

    // Fill level never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // The two front cells stay in key order.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> entry_key(links[0].entry) <= entry_key(links[1].entry))
        else $error("queue head out of order");

    // A load into a full queue is flagged and leaves the fill level alone.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_LOAD) && queue_full |=> load_dropped && queue_full)
        else $error("load into full queue not dropped");

endmodule

FILE: src/pps_cell.sv
module pps_cell
    import pps_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  cell_link_t below,   // neighbor on the head side
    input  cell_link_t above,   // neighbor on the tail side
    output cell_link_t link
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   lt;

    // this slot holds a task that stays ahead of the broadcast key
    assign lt = occupied && (entry_key(entry_reg) < ctrl.key);

    assign link.entry = entry_reg;
    assign link.lt    = lt;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (lt)
                    entry_next = entry_reg;
                else if (below.lt)
                    entry_next = ctrl.new_entry;
                else
                    entry_next = below.entry;
            end
            CELL_POP:
                entry_next = above.entry;
            CELL_SWAP:
            begin
                // head leaves and the preempted task goes back in order
                if (above.lt)
                    entry_next = above.entry;
                else if (lt)
                    entry_next = ctrl.new_entry;
                else
                    entry_next = entry_reg;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
